[rtl/rsv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_pkg: shared types and constants for the record store and verify block
// Sizes of the credential record and store, action codes, sequencer phases,
// and the structs passed between the sequencer, the store and the top level.
// ----------------------------------------------------------------------------
package rsv_pkg;

  // Record geometry
  localparam int HALF_BYTES  = 8;    // bytes in the name and in the secret
  localparam int SLOT_STRIDE = 16;   // store bytes per player slot
  localparam int STORE_DEPTH = 256;  // bytes in the record store

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int IDX_W    = $clog2(HALF_BYTES);
  localparam int BYTE_W   = 8;
  localparam int PLAYER_W = 8;
  localparam int ACTION_W = 3;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = {BYTE_W{1'b1}};

  // Input action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_NAME   = 3'd0,
    ACT_LOAD_SECRET = 3'd1,
    ACT_REQ_REG     = 3'd2,
    ACT_REQ_VERIFY  = 3'd3,
    ACT_STEP        = 3'd4,
    ACT_NEXT_PLAYER = 3'd5
  } action_t;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WR_NAME   = 3'd1,
    PH_WR_SECRET = 3'd2,
    PH_VF_NAME   = 3'd3,
    PH_VF_SECRET = 3'd4
  } phase_t;

  // Pending start request
  typedef enum logic [1:0] {
    REQ_NONE     = 2'd0,
    REQ_REGISTER = 2'd1,
    REQ_VERIFY   = 2'd2
  } req_t;

  // Store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // Status after an action
  typedef struct packed {
    logic busy;
    logic ok;
    logic differs;
  } status_t;

endpackage

[rtl/rsv_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module rsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/rsv_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_store: record store with erased-state tracking
// RAM plus one written bit per byte; an unwritten byte reads as erased.
// ----------------------------------------------------------------------------
module rsv_store (
  input  logic                      clk,
  input  logic                      rst,
  input  rsv_pkg::store_wr_t        wr,
  input  logic [rsv_pkg::ADDR_W-1:0] rd_addr,
  output logic [rsv_pkg::BYTE_W-1:0] rd_byte
);
  import rsv_pkg::*;

  logic [STORE_DEPTH-1:0] written;
  logic                   rd_written;
  logic [BYTE_W-1:0]      ram_q;

  rsv_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Written bits, looked up alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  assign rd_byte = rd_written ? ram_q : ERASED_BYTE;

endmodule

[rtl/rsv_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_seq: credential buffers and register/verify sequencer
// Loads the name and secret buffers, walks the record one byte per step,
// writes or compares store bytes, and keeps the result flags.
// ----------------------------------------------------------------------------
module rsv_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [rsv_pkg::ACTION_W-1:0] action,
  input  logic [rsv_pkg::IDX_W-1:0]    byte_index,
  input  logic [rsv_pkg::BYTE_W-1:0]   char_value,
  input  logic [rsv_pkg::BYTE_W-1:0]   rd_byte,
  output logic [rsv_pkg::ADDR_W-1:0]   rd_addr,
  output rsv_pkg::store_wr_t           wr,
  output rsv_pkg::status_t             status_next
);
  import rsv_pkg::*;

  logic [BYTE_W-1:0] name_buf   [HALF_BYTES];
  logic [BYTE_W-1:0] secret_buf [HALF_BYTES];

  phase_t              phase, phase_next;
  req_t                start_req, start_req_next;
  logic [ADDR_W-1:0]   store_addr, store_addr_next;
  logic [IDX_W-1:0]    byte_cnt, byte_cnt_next;
  logic [PLAYER_W-1:0] player_cnt, player_cnt_next;
  logic                success, success_next;
  logic                differs, differs_next;

  logic [BYTE_W-1:0] name_byte;
  logic [BYTE_W-1:0] secret_byte;
  logic              last_byte;
  logic [ADDR_W-1:0] slot_base;

  assign name_byte   = name_buf[byte_cnt];
  assign secret_byte = secret_buf[byte_cnt];
  assign last_byte   = (byte_cnt == IDX_W'(HALF_BYTES - 1));
  assign slot_base   = ADDR_W'(player_cnt * SLOT_STRIDE);

  // Buffer loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HALF_BYTES; i++) begin
        name_buf[i]   <= '0;
        secret_buf[i] <= '0;
      end
    end else if (accept) begin
      if (action == ACT_LOAD_NAME) begin
        name_buf[byte_index] <= char_value;
      end
      if (action == ACT_LOAD_SECRET) begin
        secret_buf[byte_index] <= char_value;
      end
    end
  end

  // Next state for one accepted action
  always_comb begin
    phase_next      = phase;
    start_req_next  = start_req;
    store_addr_next = store_addr;
    byte_cnt_next   = byte_cnt;
    player_cnt_next = player_cnt;
    success_next    = success;
    differs_next    = differs;
    wr.en           = 1'b0;
    wr.addr         = store_addr;
    wr.data         = name_byte;

    if (accept) begin
      unique case (action_t'(action))
        ACT_REQ_REG: begin
          if (phase == PH_IDLE) start_req_next = REQ_REGISTER;
        end
        ACT_REQ_VERIFY: begin
          if (phase == PH_IDLE) start_req_next = REQ_VERIFY;
        end
        ACT_NEXT_PLAYER: begin
          player_cnt_next = player_cnt + 1'b1;
        end
        ACT_STEP: begin
          unique case (phase)
            PH_IDLE: begin
              if (start_req != REQ_NONE) begin
                success_next    = 1'b0;
                store_addr_next = slot_base;
                byte_cnt_next   = '0;
                if (start_req == REQ_REGISTER) begin
                  phase_next = PH_WR_NAME;
                end else begin
                  differs_next = 1'b0;
                  phase_next   = PH_VF_NAME;
                end
              end
            end
            PH_WR_NAME, PH_WR_SECRET: begin
              wr.en           = 1'b1;
              wr.data         = (phase == PH_WR_SECRET) ? secret_byte : name_byte;
              store_addr_next = store_addr + 1'b1;
              byte_cnt_next   = last_byte ? '0 : byte_cnt + 1'b1;
              if (last_byte) begin
                if (phase == PH_WR_NAME) begin
                  phase_next = PH_WR_SECRET;
                end else begin
                  success_next   = 1'b1;
                  phase_next     = PH_IDLE;
                  start_req_next = REQ_NONE;
                end
              end
            end
            PH_VF_NAME, PH_VF_SECRET: begin
              if (rd_byte != ((phase == PH_VF_SECRET) ? secret_byte : name_byte)) begin
                // Mismatch ends the verify
                differs_next   = 1'b1;
                phase_next     = PH_IDLE;
                byte_cnt_next  = '0;
                start_req_next = REQ_NONE;
              end else begin
                store_addr_next = store_addr + 1'b1;
                byte_cnt_next   = last_byte ? '0 : byte_cnt + 1'b1;
                if (last_byte) begin
                  if (phase == PH_VF_NAME) begin
                    phase_next = PH_VF_SECRET;
                  end else begin
                    success_next   = 1'b1;
                    phase_next     = PH_IDLE;
                    start_req_next = REQ_NONE;
                  end
                end
              end
            end
            default: begin
              phase_next     = PH_IDLE;
              byte_cnt_next  = '0;
              start_req_next = REQ_NONE;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Status seen after the action
  always_comb begin
    status_next.busy    = (phase_next != PH_IDLE);
    status_next.ok      = success_next;
    status_next.differs = differs_next;
  end

  // Prefetch the byte the next verify step compares
  assign rd_addr = store_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      start_req  <= REQ_NONE;
      store_addr <= '0;
      byte_cnt   <= '0;
      player_cnt <= '0;
      success    <= 1'b0;
      differs    <= 1'b0;
    end else begin
      phase      <= phase_next;
      start_req  <= start_req_next;
      store_addr <= store_addr_next;
      byte_cnt   <= byte_cnt_next;
      player_cnt <= player_cnt_next;
      success    <= success_next;
      differs    <= differs_next;
    end
  end

endmodule

[rtl/record_store_and_verify_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_store_and_verify_top: credential record store with register/verify
// Name and secret buffers, a 256-byte record store and a byte-serial
// sequencer; every accepted action returns one status transfer.
// ----------------------------------------------------------------------------
// Each accepted action produces exactly one status transfer, presented in the
// next cycle; a new action is taken every cycle while the status register is
// empty or being drained. A register takes one request action plus 17 step
// actions (one to start, one per record byte); a verify takes up to 17 steps
// and stops early on the first differing byte. Every write or compare step
// touches one store byte via the RAM write port or registered read port; the
// byte a verify step compares is read ahead at the address the sequencer
// will use next. The store reads as erased (all ones) right after reset
// with no clearing pass; per-byte written bits track which entries hold data.
// ----------------------------------------------------------------------------
module record_store_and_verify_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rsv_pkg::ACTION_W-1:0] action,
  input  logic [rsv_pkg::IDX_W-1:0]    byte_index,
  input  logic [rsv_pkg::BYTE_W-1:0]   char_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         busy_res,
  output logic                         registered_ok,
  output logic                         data_differs
);
  import rsv_pkg::*;

  logic              accept;
  logic [BYTE_W-1:0] rd_byte;
  logic [ADDR_W-1:0] rd_addr;
  store_wr_t         wr;
  status_t           status_next;

  // Take a transfer when the status register is free or drains now
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  rsv_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .byte_index  (byte_index),
    .char_value  (char_value),
    .rd_byte     (rd_byte),
    .rd_addr     (rd_addr),
    .wr          (wr),
    .status_next (status_next)
  );

  rsv_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_byte (rd_byte)
  );

  // Status output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      busy_res      <= status_next.busy;
      registered_ok <= status_next.ok;
      data_differs  <= status_next.differs;
    end
  end

endmodule

[tb/record_store_and_verify_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_store_and_verify_top_tb: self-checking bench for the credential store
// Drives name/secret loads, register and verify sequences, player changes and
// noise through the action channel under several idle and stall mixes. A
// scoreboard class tracks buffers, store and sequencer state, predicts the
// status returned for each action, and checks every status transfer in order.
// ----------------------------------------------------------------------------
module record_store_and_verify_top_tb;
  import rsv_pkg::*;

  // Action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [BYTE_W-1:0]   ZERO_BYTE     = '0;
  localparam int                  SEQ_STEPS     = 2 * HALF_BYTES + 1;
  localparam int                  RANDOM_ITEMS  = 500;

  // Predicts the status after each accepted action and checks it in order
  class credential_scoreboard;
    logic [BYTE_W-1:0] store_mem  [STORE_DEPTH];
    logic [BYTE_W-1:0] name_buf   [HALF_BYTES];
    logic [BYTE_W-1:0] secret_buf [HALF_BYTES];
    phase_t            seq_phase;
    req_t              pending_req;
    int unsigned       store_addr;
    int unsigned       byte_pos;
    logic [PLAYER_W-1:0] player;
    logic              ok_flag;
    logic              diff_flag;
    status_t           status_due_q[$];
    int unsigned       errors;

    function new();
      foreach (store_mem[i]) store_mem[i] = ERASED_BYTE;
      foreach (name_buf[i]) begin
        name_buf[i]   = '0;
        secret_buf[i] = '0;
      end
      seq_phase   = PH_IDLE;
      pending_req = REQ_NONE;
      store_addr  = 0;
      byte_pos    = 0;
      player      = '0;
      ok_flag     = 1'b0;
      diff_flag   = 1'b0;
      errors      = 0;
    endfunction

    function int unsigned outstanding();
      return status_due_q.size();
    endfunction

    // Move to the next store byte; returns 1 when a half record is done
    function bit advance();
      store_addr = (store_addr + 1) % STORE_DEPTH;
      if (byte_pos + 1 >= HALF_BYTES) begin
        byte_pos = 0;
        return 1'b1;
      end
      byte_pos++;
      return 1'b0;
    endfunction

    function void end_sequence();
      seq_phase   = PH_IDLE;
      byte_pos    = 0;
      pending_req = REQ_NONE;
    endfunction

    function void step_sequencer();
      case (seq_phase)
        PH_IDLE: begin
          if (pending_req != REQ_NONE) begin
            ok_flag    = 1'b0;
            store_addr = (int'(player) * SLOT_STRIDE) % STORE_DEPTH;
            byte_pos   = 0;
            if (pending_req == REQ_REGISTER) begin
              seq_phase = PH_WR_NAME;
            end else begin
              diff_flag = 1'b0;
              seq_phase = PH_VF_NAME;
            end
          end
        end
        PH_WR_NAME: begin
          store_mem[store_addr] = name_buf[byte_pos];
          if (advance()) seq_phase = PH_WR_SECRET;
        end
        PH_WR_SECRET: begin
          store_mem[store_addr] = secret_buf[byte_pos];
          if (advance()) begin
            ok_flag = 1'b1;
            end_sequence();
          end
        end
        PH_VF_NAME: begin
          if (store_mem[store_addr] != name_buf[byte_pos]) begin
            diff_flag = 1'b1;
            end_sequence();
          end else if (advance()) begin
            seq_phase = PH_VF_SECRET;
          end
        end
        PH_VF_SECRET: begin
          if (store_mem[store_addr] != secret_buf[byte_pos]) begin
            diff_flag = 1'b1;
            end_sequence();
          end else if (advance()) begin
            ok_flag = 1'b1;
            end_sequence();
          end
        end
        default: end_sequence();
      endcase
    endfunction

    function void note_action(logic [ACTION_W-1:0] act, logic [IDX_W-1:0] idx,
                              logic [BYTE_W-1:0] val);
      status_t s;
      case (act)
        ACT_LOAD_NAME:   if (idx < HALF_BYTES) name_buf[idx] = val;
        ACT_LOAD_SECRET: if (idx < HALF_BYTES) secret_buf[idx] = val;
        ACT_REQ_REG:     if (seq_phase == PH_IDLE) pending_req = REQ_REGISTER;
        ACT_REQ_VERIFY:  if (seq_phase == PH_IDLE) pending_req = REQ_VERIFY;
        ACT_STEP:        step_sequencer();
        ACT_NEXT_PLAYER: player = player + 1'b1;
        default: ;
      endcase
      s.busy    = (seq_phase != PH_IDLE);
      s.ok      = ok_flag;
      s.differs = diff_flag;
      status_due_q.push_back(s);
    endfunction

    function void check_status(logic busy, logic ok, logic differs);
      status_t want;
      if (status_due_q.size() == 0) begin
        $error("status transfer with none expected");
        errors++;
        return;
      end
      want = status_due_q.pop_front();
      if (busy !== want.busy) begin
        $error("busy_res: expected %0b, got %0b", want.busy, busy);
        errors++;
      end
      if (ok !== want.ok) begin
        $error("registered_ok: expected %0b, got %0b", want.ok, ok);
        errors++;
      end
      if (differs !== want.differs) begin
        $error("data_differs: expected %0b, got %0b", want.differs, differs);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] action;
  logic [IDX_W-1:0]    byte_index;
  logic [BYTE_W-1:0]   char_value;
  logic                out_valid;
  logic                out_stall;
  logic                busy_res;
  logic                registered_ok;
  logic                data_differs;

  credential_scoreboard sb;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          sent_count;

  record_store_and_verify_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .byte_index    (byte_index),
    .char_value    (char_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .busy_res      (busy_res),
    .registered_ok (registered_ok),
    .data_differs  (data_differs)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Status checking on the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_status(busy_res, registered_ok, data_differs);
    end
  end

  // One action transfer; entered and left at a falling edge
  task automatic send(logic [ACTION_W-1:0] act, logic [IDX_W-1:0] idx,
                      logic [BYTE_W-1:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    byte_index <= idx;
    char_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_action(act, idx, val);
    if (act < ACT_UNUSED_LO) sent_count++;
    @(negedge clk);
  endtask

  task automatic send_noise();
    send(ACTION_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
         BYTE_W'($urandom_range(255)));
  endtask

  // Request followed by the steps of a full sequence; meddle mixes in
  // stray actions and may cut the sequence short
  task automatic run_sequence(logic [ACTION_W-1:0] req, bit meddle);
    int unsigned steps;
    steps = meddle ? $urandom_range(1, SEQ_STEPS) : SEQ_STEPS + $urandom_range(0, 2);
    send(req, IDX_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
    repeat (steps) begin
      if (meddle && $urandom_range(99) < 20) send_noise();
      send(ACT_STEP, IDX_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic load_bytes(int unsigned count, bit all_ones);
    repeat (count) begin
      send($urandom_range(1) ? ACT_LOAD_SECRET : ACT_LOAD_NAME,
           IDX_W'($urandom_range(7)),
           all_ones ? ERASED_BYTE : BYTE_W'($urandom_range(255)));
    end
  endtask

  // Mix of well-formed sequences with random content, plus broken ones and noise
  task automatic run_random(int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent_count + quota;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        load_bytes($urandom_range(0, 16), 1'b0);
        run_sequence(ACT_REQ_REG, 1'b0);
      end else if (pick < 55) begin
        if ($urandom_range(1)) load_bytes(1, 1'b0);
        run_sequence(ACT_REQ_VERIFY, 1'b0);
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 17)) begin
          send(ACT_NEXT_PLAYER, IDX_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
        end
      end else if (pick < 72) begin
        // all-ones buffers match an erased slot
        for (int i = 0; i < HALF_BYTES; i++) begin
          send(ACT_LOAD_NAME, IDX_W'(i), ERASED_BYTE);
          send(ACT_LOAD_SECRET, IDX_W'(i), ERASED_BYTE);
        end
      end else if (pick < 90) begin
        run_sequence($urandom_range(1) ? ACT_REQ_VERIFY : ACT_REQ_REG, 1'b1);
      end else begin
        repeat ($urandom_range(1, 5)) send_noise();
      end
    end
  endtask

  // Main sequence
  initial begin
    sb             = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_LOAD_NAME;
    byte_index     = '0;
    char_value     = ZERO_BYTE;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_count     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ignored codes, idle step, buffer extremes, early mismatch
    send(ACT_UNUSED_LO, 3'd7, ERASED_BYTE);
    send(ACT_UNUSED_HI, 3'd0, ZERO_BYTE);
    send(ACT_STEP, 3'd0, ZERO_BYTE);
    send(ACT_LOAD_NAME, 3'd0, ZERO_BYTE);
    send(ACT_LOAD_NAME, 3'd7, ERASED_BYTE);
    send(ACT_LOAD_SECRET, 3'd0, ERASED_BYTE);
    send(ACT_LOAD_SECRET, 3'd7, ZERO_BYTE);
    send(ACT_NEXT_PLAYER, 3'd7, ERASED_BYTE);
    send(ACT_REQ_VERIFY, 3'd0, ZERO_BYTE);
    send(ACT_STEP, 3'd0, ZERO_BYTE);
    // request while busy is dropped
    send(ACT_REQ_REG, 3'd0, ZERO_BYTE);
    // erased store byte against name byte zero
    send(ACT_STEP, 3'd0, ZERO_BYTE);
    send(ACT_STEP, 3'd0, ZERO_BYTE);

    // Random phases with different idle and stall mixes
    run_random(RANDOM_ITEMS);
    send_idle_pct = 62;
    run_random(RANDOM_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    run_random(RANDOM_ITEMS);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    run_random(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
